/* src/e8ctu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e8ctu_pkg
// Shared types and constants of the E8 call translation undo core.
// ----------------------------------------------------------------------------
package e8ctu_pkg;

   localparam int unsigned MAX_CHUNK_BYTES_DEF = 32768;
   localparam logic [7:0] CALL_OPCODE = 8'hE8;
   localparam int unsigned CALL_GUARD = 10;
   localparam int unsigned OPERAND_BYTES = 4;
   localparam int unsigned GROUP_DEPTH = 4;
   localparam logic [30:0] TSIZE_RESET = 31'd12000000;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0] REG_TSIZE = 1'b0;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_of_chunk;
      logic [15:0] chunk_len;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       chunk_last;
   } rsp_type;

   typedef struct packed {
      rsp_type [GROUP_DEPTH-1:0] entry;
      logic [2:0]                count;
   } group_type;

endpackage
`default_nettype wire

/* src/e8ctu_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e8ctu_csr
// Configuration register file with an APB-style access port.
// ----------------------------------------------------------------------------
module e8ctu_csr
   import e8ctu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output logic [30:0]                tsize
);

   logic [30:0] tsize_ff;
   logic [30:0] tsize_in;
   logic        reg_sel;

   assign reg_sel = (paddr[CSR_ADDR_W-1 -: 1] == REG_TSIZE);

   always_comb begin
      tsize_in = tsize_ff;
      if (psel && penable && pwrite && reg_sel) begin
         tsize_in = pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= TSIZE_RESET;
      end else begin
         tsize_ff <= tsize_in;
      end
   end

   assign prdata = reg_sel ? {1'b0, tsize_ff} : 32'd0;
   assign pready = 1'b1;
   assign tsize  = tsize_ff;

endmodule
`default_nettype wire

/* src/e8ctu_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e8ctu_scan
// Chunk scanner: position tracking, operand gathering and translation undo.
// Produces the whole result group of one input beat in one pass.
// ----------------------------------------------------------------------------
module e8ctu_scan
   import e8ctu_pkg::*;
#(
   parameter int unsigned MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire req_type     req,
   input  wire logic [30:0] tsize,
   output group_type        group
);

   localparam logic [16:0] MAX_LEN = 17'(MAX_CHUNK_BYTES);

   logic [15:0] pos_ff, pos_in;
   logic [2:0]  gc_ff, gc_in;
   logic [31:0] hold_ff, hold_in;
   logic [15:0] callpos_ff, callpos_in;
   logic [15:0] len_ff, len_in;

   logic [2:0]  gc_eff;
   logic [31:0] hold_eff;
   logic [15:0] pos;
   logic [15:0] len_eff;
   logic [2:0]  flush_n;
   logic        is_last;
   logic        gathering;
   logic        complete;
   logic [2:0]  lane;
   logic [31:0] word;
   logic        start_call;
   logic signed [33:0] a_s;
   logic signed [33:0] p_s;
   logic signed [33:0] ts_s;
   logic signed [33:0] low_sum;
   logic signed [33:0] res_s;
   logic        in_range;
   logic [31:0] xword;
   rsp_type     byte_rsp;

   always_comb begin
      if (req.first_of_chunk) begin
         gc_eff   = 3'd0;
         hold_eff = 32'd0;
         pos      = 16'd0;
         len_eff  = ({1'b0, req.chunk_len} > MAX_LEN) ? MAX_LEN[15:0] : req.chunk_len;
      end else begin
         gc_eff   = gc_ff;
         hold_eff = hold_ff;
         pos      = pos_ff;
         len_eff  = len_ff;
      end
      flush_n = (req.first_of_chunk && gc_ff != 3'd0 && gc_ff <= 3'(OPERAND_BYTES)) ?
                gc_ff - 3'd1 : 3'd0;
      is_last    = (({1'b0, pos} + 17'd1) == {1'b0, len_eff});
      gathering  = (gc_eff != 3'd0) && (gc_eff <= 3'(OPERAND_BYTES));
      complete   = gathering && (gc_eff == 3'(OPERAND_BYTES));
      lane       = gc_eff - 3'd1;
      start_call = (req.data_byte == CALL_OPCODE) &&
                   (({1'b0, pos} + 17'(CALL_GUARD)) < {1'b0, len_eff});
      for (int j = 0; j < OPERAND_BYTES; j++) begin
         word[8*j +: 8] = (lane == 3'(j)) ? req.data_byte : hold_eff[8*j +: 8];
      end

      a_s      = {{2{word[31]}}, word};
      p_s      = {18'd0, callpos_ff};
      ts_s     = {3'd0, tsize};
      low_sum  = a_s + p_s;
      in_range = !low_sum[33] && (a_s < ts_s);
      res_s    = word[31] ? (a_s + ts_s) : (a_s - p_s);
      xword    = in_range ? res_s[31:0] : word;

      byte_rsp.out_byte   = req.data_byte;
      byte_rsp.run_last   = 1'b1;
      byte_rsp.chunk_last = is_last;

      for (int i = 0; i < GROUP_DEPTH; i++) begin
         if (complete) begin
            group.entry[i].out_byte   = xword[8*i +: 8];
            group.entry[i].run_last   = (i == GROUP_DEPTH - 1);
            group.entry[i].chunk_last = (i == GROUP_DEPTH - 1) && is_last;
         end else if (3'(i) < flush_n) begin
            group.entry[i].out_byte   = hold_ff[8*i +: 8];
            group.entry[i].run_last   = 1'b0;
            group.entry[i].chunk_last = 1'b0;
         end else begin
            group.entry[i] = byte_rsp;
         end
      end
      if (complete) begin
         group.count = 3'(GROUP_DEPTH);
      end else if (gathering) begin
         group.count = 3'd0;
      end else begin
         group.count = flush_n + 3'd1;
      end

      pos_in     = pos_ff;
      gc_in      = gc_ff;
      hold_in    = hold_ff;
      callpos_in = callpos_ff;
      len_in     = len_ff;
      if (accept) begin
         pos_in = (pos == 16'hFFFF) ? 16'hFFFF : pos + 16'd1;
         len_in = len_eff;
         if (gathering) begin
            if (complete) begin
               gc_in   = 3'd0;
               hold_in = 32'd0;
            end else begin
               gc_in   = gc_eff + 3'd1;
               hold_in = word;
            end
         end else if (start_call) begin
            gc_in      = 3'd1;
            hold_in    = 32'd0;
            callpos_in = pos;
         end else begin
            gc_in   = 3'd0;
            hold_in = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 16'd0;
         gc_ff      <= 3'd0;
         hold_ff    <= 32'd0;
         callpos_ff <= 16'd0;
         len_ff     <= 16'd0;
      end else begin
         pos_ff     <= pos_in;
         gc_ff      <= gc_in;
         hold_ff    <= hold_in;
         callpos_ff <= callpos_in;
         len_ff     <= len_in;
      end
   end

endmodule
`default_nettype wire

/* src/e8ctu_outq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e8ctu_outq
// Result register bank: holds one result group and sends it out beat by beat.
// ----------------------------------------------------------------------------
module e8ctu_outq
   import e8ctu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      accept,
   input  wire group_type group,
   output logic           ready,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_data
);

   rsp_type [GROUP_DEPTH-1:0] q_ff, q_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic                      pop;

   assign pop   = (cnt_ff != 3'd0) && !rsp_stall;
   assign ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && !rsp_stall);

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (accept && group.count != 3'd0) begin
         q_in   = group.entry;
         cnt_in = group.count;
      end else if (pop) begin
         for (int i = 0; i < GROUP_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_data  = q_ff[0];

endmodule
`default_nettype wire

/* src/e8_call_translation_undo_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e8_call_translation_undo_core
// Streaming undo of the x86 CALL (E8) operand translation on chunk data.
// ----------------------------------------------------------------------------
// Usage: bytes of a decompressed chunk enter on the req channel, one per beat,
// with first_of_chunk set on the first byte together with the chunk length.
// Results leave on the rsp channel, one byte per beat. An E8 byte is passed
// on at once; when its position plus ten is below the chunk length, its four
// operand bytes are held and leave as four beats when the fourth arrives,
// translated back when in range. A beat's first result appears on rsp_data in
// the cycle after the beat is taken. A beat that causes at most one result is
// taken every cycle while the receiver does not stall; a beat that causes more
// holds req_stall while the result bank drains, since the output port moves
// one byte per cycle when not stalled. The translation size register is
// written over the APB-style port; the user must do so only while the stream
// is idle, as the core does not enforce it. Reset clears the scan state and
// the result bank and loads the default translation size. When the receiver
// stalls, the pending result stays on rsp_data and the core stalls its input.
// ----------------------------------------------------------------------------
module e8_call_translation_undo_core
   import e8ctu_pkg::*;
#(
   parameter int unsigned MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic [30:0] tsize;
   logic        ready;
   logic        accept;
   group_type   group;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   e8ctu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .tsize   (tsize)
   );

   e8ctu_scan #(
      .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .tsize  (tsize),
      .group  (group)
   );

   e8ctu_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .group     (group),
      .ready     (ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* src/e8ctu_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e8ctu_checker
// Port-level checks of the E8 call translation undo core.
// ----------------------------------------------------------------------------
module e8ctu_checker
   import e8ctu_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result beat changed or dropped.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat present right after reset.");

   a_chunk_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chunk_last |-> rsp_data.run_last)
      else $error("Chunk end flagged on a beat that does not end its run.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input taken while the result bank cannot drain.");

endmodule

bind e8_call_translation_undo_core e8ctu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
